// ===== src/hbt_pkg.sv =====
// Package for the host binding table: operation and status codes, defaults and handshake types.
`timescale 1ns / 1ps
`default_nettype none
package hbt_pkg;

	// Defaults for the top-level parameters.
	localparam int TABLE_ENTRIES_DEF = 32;
	localparam int FLAG_BITS_DEF = 32;

	// Fixed field widths of one word on the ports.
	localparam int MAC_W = 48;
	localparam int IP_W = 32;
	localparam int FLAG_IN_W = 32;
	localparam int MODE_W = 3;
	localparam int STATUS_W = 2;
	localparam int TOTAL_W = 6;

	// Operation codes.
	localparam logic [MODE_W-1:0] MODE_LEARN = 3'd0;
	localparam logic [MODE_W-1:0] MODE_DELETE = 3'd1;
	localparam logic [MODE_W-1:0] MODE_REGISTER = 3'd2;
	localparam logic [MODE_W-1:0] MODE_UPDATE = 3'd3;
	localparam logic [MODE_W-1:0] MODE_SEARCH = 3'd4;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;
	localparam logic [STATUS_W-1:0] ST_CLEARED = 2'd3;

	// IP value stored by a register operation.
	localparam logic [IP_W-1:0] ZERO_IP = '0;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic eval;
		logic finish;
		logic add;
	} hbt_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic scan_end;
		logic stop;
		logic need_append;
	} hbt_stat_t;

endpackage
`default_nettype wire

// ===== src/host_binding_table.sv =====
// Top level of the host binding table: controller and datapath.
//
// Usage: a request word (mode, mac_addr, ip_addr, block_flags) is taken at a
// rising edge where start is high and busy is low. The block then stays busy
// until it shows one result word (status, found_mac, found_flags, entry_total)
// for exactly one cycle with done high. The receiver cannot hold results off.
// Entries live in one RAM with a registered read port; every scan step has a
// read state that reads an entry and an evaluate state that evaluates and
// possibly writes it. Learn, delete, update and a search that finds nothing
// walk all n valid entries, and a learn that appends or clears adds an append
// step. Search stops at the first IP match. Register goes straight to the
// append step, and an unknown mode goes straight from idle to the done
// state. Delete compacts the table in the same pass with a separate
// write pointer. After done the block is idle and can take the next word in
// the next cycle. Reset empties the table (entry count zero) and returns the
// controller to idle; the RAM contents are not cleared, since only entries
// below the count are ever read.
`timescale 1ns / 1ps
`default_nettype none
module host_binding_table #(
	parameter int TABLE_ENTRIES = hbt_pkg::TABLE_ENTRIES_DEF,
	parameter int FLAG_BITS = hbt_pkg::FLAG_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	output logic                                  busy,
	input  wire logic [hbt_pkg::MODE_W-1:0]       mode,
	input  wire logic [hbt_pkg::MAC_W-1:0]        mac_addr,
	input  wire logic [hbt_pkg::IP_W-1:0]         ip_addr,
	input  wire logic [hbt_pkg::FLAG_IN_W-1:0]    block_flags,
	output logic                                  done,
	output logic      [hbt_pkg::STATUS_W-1:0]     status,
	output logic      [hbt_pkg::MAC_W-1:0]        found_mac,
	output logic      [hbt_pkg::FLAG_IN_W-1:0]    found_flags,
	output logic      [hbt_pkg::TOTAL_W-1:0]      entry_total
);
	import hbt_pkg::*;

	hbt_cmd_t  cmd;
	hbt_stat_t stat;

	hbt_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.mode  (mode),
		.stat  (stat),
		.cmd   (cmd),
		.busy  (busy),
		.done  (done)
	);

	hbt_datapath #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.FLAG_BITS    (FLAG_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.mode       (mode),
		.mac_addr   (mac_addr),
		.ip_addr    (ip_addr),
		.block_flags(block_flags),
		.status     (status),
		.found_mac  (found_mac),
		.found_flags(found_flags),
		.entry_total(entry_total)
	);

endmodule
`default_nettype wire

// ===== src/hbt_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module hbt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== src/hbt_ctrl.sv =====
// Controller state machine that sequences table scans, appends and the result strobe.
`timescale 1ns / 1ps
`default_nettype none
module hbt_ctrl (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [hbt_pkg::MODE_W-1:0]    mode,
	input  wire hbt_pkg::hbt_stat_t            stat,
	output hbt_pkg::hbt_cmd_t                  cmd,
	output logic                               busy,
	output logic                               done
);
	import hbt_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN_RD = 3'd1;
	localparam logic [2:0] S_SCAN_EV = 3'd2;
	localparam logic [2:0] S_END = 3'd3;
	localparam logic [2:0] S_ADD = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					case (mode)
						MODE_LEARN, MODE_DELETE, MODE_UPDATE, MODE_SEARCH: state_d = S_SCAN_RD;
						MODE_REGISTER: state_d = S_ADD;
						default: state_d = S_DONE;
					endcase
				end
			end
			S_SCAN_RD: begin
				state_d = stat.scan_end ? S_END : S_SCAN_EV;
			end
			S_SCAN_EV: begin
				cmd.eval = 1'b1;
				state_d = stat.stop ? S_DONE : S_SCAN_RD;
			end
			S_END: begin
				cmd.finish = 1'b1;
				state_d = stat.need_append ? S_ADD : S_DONE;
			end
			S_ADD: begin
				cmd.add = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

	// An accepted word always makes the block busy in the next cycle.
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted word did not raise busy");

	// The result strobe lasts exactly one cycle and returns to idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> (state_q == S_IDLE))
		else $error("result strobe not followed by idle");

	// At most one datapath command is issued in any cycle.
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("conflicting datapath commands");

endmodule
`default_nettype wire

// ===== src/hbt_datapath.sv =====
// Datapath: request registers, scan pointers, entry count, table memory and result registers.
`timescale 1ns / 1ps
`default_nettype none
module hbt_datapath #(
	parameter int TABLE_ENTRIES = hbt_pkg::TABLE_ENTRIES_DEF,
	parameter int FLAG_BITS = hbt_pkg::FLAG_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire hbt_pkg::hbt_cmd_t                cmd,
	output hbt_pkg::hbt_stat_t                    stat,
	input  wire logic [hbt_pkg::MODE_W-1:0]       mode,
	input  wire logic [hbt_pkg::MAC_W-1:0]        mac_addr,
	input  wire logic [hbt_pkg::IP_W-1:0]         ip_addr,
	input  wire logic [hbt_pkg::FLAG_IN_W-1:0]    block_flags,
	output logic      [hbt_pkg::STATUS_W-1:0]     status,
	output logic      [hbt_pkg::MAC_W-1:0]        found_mac,
	output logic      [hbt_pkg::FLAG_IN_W-1:0]    found_flags,
	output logic      [hbt_pkg::TOTAL_W-1:0]      entry_total
);
	import hbt_pkg::*;

	localparam int AW = $clog2(TABLE_ENTRIES);
	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam int EW = MAC_W + IP_W + FLAG_BITS;
	localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_ENTRIES);

	// Latched request word.
	logic [MODE_W-1:0]    mode_q;
	logic [MAC_W-1:0]     mac_q;
	logic [IP_W-1:0]      ip_q;
	logic [FLAG_BITS-1:0] flags_q;

	// Scan and table state.
	logic [CW-1:0]        count_q;
	logic [CW-1:0]        rp_q;
	logic [CW-1:0]        wp_q;
	logic                 hit_q;
	logic                 change_q;

	// Result registers.
	logic [STATUS_W-1:0]  status_q;
	logic [MAC_W-1:0]     fmac_q;
	logic [FLAG_BITS-1:0] fflags_q;

	// Memory port signals.
	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [EW-1:0]        ram_wdata;
	logic [EW-1:0]        rd_data;

	// Fields of the entry read in the previous cycle.
	logic [MAC_W-1:0]     e_mac;
	logic [IP_W-1:0]      e_ip;
	logic [FLAG_BITS-1:0] e_flags;
	logic                 mac_eq;
	logic                 ip_eq;
	logic                 learn_chg;

	assign e_flags = rd_data[FLAG_BITS-1:0];
	assign e_ip = rd_data[FLAG_BITS +: IP_W];
	assign e_mac = rd_data[FLAG_BITS + IP_W +: MAC_W];
	assign mac_eq = (e_mac == mac_q);
	assign ip_eq = (e_ip == ip_q);

	// On the first MAC match a learn decides whether the IP changes; later matches follow it.
	assign learn_chg = hit_q ? change_q : !ip_eq;

	hbt_ram #(
		.WIDTH(EW),
		.DEPTH(TABLE_ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(rp_q[AW-1:0]),
		.rdata(rd_data)
	);

	// Status back to the controller.
	assign stat.scan_end = (rp_q >= count_q);
	assign stat.stop = (mode_q == MODE_SEARCH) && ip_eq;
	assign stat.need_append = (mode_q == MODE_LEARN) && !hit_q;

	// Memory write selection for scan updates, compaction and appends.
	always_comb begin
		ram_we = 1'b0;
		ram_waddr = rp_q[AW-1:0];
		ram_wdata = rd_data;
		if (cmd.eval) begin
			case (mode_q)
				MODE_LEARN: begin
					ram_we = mac_eq && learn_chg;
					ram_wdata = {e_mac, ip_q, e_flags};
				end
				MODE_DELETE: begin
					ram_we = !mac_eq;
					ram_waddr = wp_q[AW-1:0];
				end
				MODE_UPDATE: begin
					ram_we = mac_eq;
					ram_wdata = {e_mac, e_ip, flags_q};
				end
				default: begin
					ram_we = 1'b0;
				end
			endcase
		end else if (cmd.add) begin
			ram_we = (count_q != FULL_COUNT);
			ram_waddr = count_q[AW-1:0];
			if (mode_q == MODE_LEARN) begin
				ram_wdata = {mac_q, ip_q, {FLAG_BITS{1'b0}}};
			end else begin
				ram_wdata = {mac_q, ZERO_IP, flags_q};
			end
		end
	end

	// Request word, held for the whole operation.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode;
			mac_q <= mac_addr;
			ip_q <= ip_addr;
			flags_q <= FLAG_BITS'(block_flags);
		end
	end

	// Control state: pointers, count, hit tracking and result status.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			rp_q <= '0;
			wp_q <= '0;
			hit_q <= 1'b0;
			change_q <= 1'b0;
			status_q <= ST_DONE;
		end else begin
			if (cmd.load) begin
				rp_q <= '0;
				wp_q <= '0;
				hit_q <= 1'b0;
				change_q <= 1'b0;
				status_q <= ST_DONE;
			end
			if (cmd.eval) begin
				rp_q <= rp_q + 1'b1;
				case (mode_q)
					MODE_LEARN: begin
						if (mac_eq) begin
							hit_q <= 1'b1;
							change_q <= learn_chg;
						end
					end
					MODE_DELETE: begin
						if (mac_eq) begin
							hit_q <= 1'b1;
						end else begin
							wp_q <= wp_q + 1'b1;
						end
					end
					MODE_UPDATE: begin
						if (mac_eq) begin
							hit_q <= 1'b1;
						end
					end
					MODE_SEARCH: begin
						if (ip_eq) begin
							hit_q <= 1'b1;
						end
					end
					default: begin
						hit_q <= hit_q;
					end
				endcase
			end
			if (cmd.finish) begin
				if (mode_q == MODE_DELETE) begin
					count_q <= wp_q;
				end
				if (!hit_q && (mode_q == MODE_DELETE || mode_q == MODE_UPDATE ||
						mode_q == MODE_SEARCH)) begin
					status_q <= ST_NOT_FOUND;
				end
			end
			if (cmd.add) begin
				if (count_q != FULL_COUNT) begin
					count_q <= count_q + 1'b1;
				end else if (mode_q == MODE_LEARN) begin
					count_q <= '0;
					status_q <= ST_CLEARED;
				end else begin
					status_q <= ST_FULL;
				end
			end
		end
	end

	// Found entry of a search; cleared for every new word.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			fmac_q <= '0;
			fflags_q <= '0;
		end else if (cmd.eval && stat.stop) begin
			fmac_q <= e_mac;
			fflags_q <= e_flags;
		end
	end

	assign status = status_q;
	assign found_mac = fmac_q;
	assign found_flags = FLAG_IN_W'(fflags_q);
	assign entry_total = TOTAL_W'(count_q);

	// The entry count never exceeds the table depth.
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_COUNT)
		else $error("entry count above table depth");

	// Compaction never writes ahead of the entry being read.
	a_wp_le_rp: assert property (@(posedge clk) disable iff (!arst_n)
		wp_q <= rp_q)
		else $error("compaction pointer passed read pointer");

	// The table is only written during a scan step or an append.
	a_we_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (cmd.eval || cmd.add))
		else $error("table write outside scan or append");

endmodule
`default_nettype wire

// ===== dv/tb_host_binding_table.sv =====
// Self-checking testbench for the host binding table: stimulus, table predictor and result checks.
`timescale 1ns / 1ps
module tb_host_binding_table;
	import hbt_pkg::*;

	localparam int TABLE_SIZE = TABLE_ENTRIES_DEF;
	localparam int CYCLE_LIMIT = 600000;
	localparam int RANDOM_WORDS = 1150;
	localparam int CALM_WORDS = 150;
	localparam int PHASE_WORDS = 115;
	localparam int SETTLE_CYCLES = 2 * TABLE_SIZE + 16;
	localparam logic [MODE_W-1:0] MODE_SPARE_LO = MODE_SEARCH + 1'b1;
	localparam logic [MODE_W-1:0] MODE_SPARE_HI = '1;

	// One result word as it appears on the result ports.
	typedef struct packed {
		logic [STATUS_W-1:0]  status;
		logic [MAC_W-1:0]     mac;
		logic [FLAG_IN_W-1:0] flags;
		logic [TOTAL_W-1:0]   total;
	} lookup_result_t;

	// Shadow copy of the host table plus the queue of predicted result words.
	class binding_scoreboard;
		logic [MAC_W-1:0]     mac_tab [TABLE_SIZE];
		logic [IP_W-1:0]      ip_tab [TABLE_SIZE];
		logic [FLAG_IN_W-1:0] flag_tab [TABLE_SIZE];
		int                   n_entries;
		lookup_result_t       pending [$];
		int                   mismatch_count;

		function new();
			n_entries = 0;
			mismatch_count = 0;
		endfunction

		function void add_entry(logic [MAC_W-1:0] mac, logic [IP_W-1:0] ip,
					logic [FLAG_IN_W-1:0] flags);
			mac_tab[n_entries] = mac;
			ip_tab[n_entries] = ip;
			flag_tab[n_entries] = flags;
			n_entries++;
		endfunction

		// Applies one accepted request word to the shadow table and queues its result.
		function void note_request(logic [MODE_W-1:0] op, logic [MAC_W-1:0] mac,
					   logic [IP_W-1:0] ip, logic [FLAG_IN_W-1:0] flags);
			lookup_result_t r;
			int first;
			int keep;
			bit hit;
			r = '0;
			r.status = ST_DONE;
			first = -1;
			keep = 0;
			hit = 1'b0;
			case (op)
				MODE_LEARN: begin
					for (int i = 0; i < n_entries; i++)
						if (first < 0 && mac_tab[i] == mac) first = i;
					if (first >= 0) begin
						// Only a changed IP is written, but then to every copy of the MAC.
						if (ip_tab[first] != ip)
							for (int i = 0; i < n_entries; i++)
								if (mac_tab[i] == mac) ip_tab[i] = ip;
					end else if (n_entries >= TABLE_SIZE) begin
						n_entries = 0;
						r.status = ST_CLEARED;
					end else begin
						add_entry(mac, ip, '0);
					end
				end
				MODE_DELETE: begin
					// Compact in place; adjacent duplicates must all go.
					for (int i = 0; i < n_entries; i++) begin
						if (mac_tab[i] == mac) begin
							hit = 1'b1;
						end else begin
							mac_tab[keep] = mac_tab[i];
							ip_tab[keep] = ip_tab[i];
							flag_tab[keep] = flag_tab[i];
							keep++;
						end
					end
					n_entries = keep;
					r.status = hit ? ST_DONE : ST_NOT_FOUND;
				end
				MODE_REGISTER: begin
					if (n_entries >= TABLE_SIZE) r.status = ST_FULL;
					else add_entry(mac, ZERO_IP, flags);
				end
				MODE_UPDATE: begin
					for (int i = 0; i < n_entries; i++) begin
						if (mac_tab[i] == mac) begin
							flag_tab[i] = flags;
							hit = 1'b1;
						end
					end
					r.status = hit ? ST_DONE : ST_NOT_FOUND;
				end
				MODE_SEARCH: begin
					for (int i = 0; i < n_entries; i++)
						if (first < 0 && ip_tab[i] == ip) first = i;
					if (first >= 0) begin
						r.mac = mac_tab[first];
						r.flags = flag_tab[first];
					end else begin
						r.status = ST_NOT_FOUND;
					end
				end
				default: begin
					// Spare modes leave the table alone.
				end
			endcase
			r.total = TOTAL_W'(n_entries);
			pending.push_back(r);
		endfunction

		task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
			$display("MISMATCH at %0t: %s got %0h expected %0h", $time, what, got, want);
			mismatch_count++;
		endtask

		// Compares one result word with the oldest prediction.
		task check_result(lookup_result_t got);
			lookup_result_t want;
			if (pending.size() == 0) begin
				report_mismatch("unrequested result word, status", got.status, '0);
				return;
			end
			want = pending.pop_front();
			if (got.status !== want.status) report_mismatch("status", got.status, want.status);
			if (got.mac !== want.mac) report_mismatch("found_mac", got.mac, want.mac);
			if (got.flags !== want.flags) report_mismatch("found_flags", got.flags, want.flags);
			if (got.total !== want.total) report_mismatch("entry_total", got.total, want.total);
		endtask
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic [MODE_W-1:0]    mode = MODE_LEARN;
	logic [MAC_W-1:0]     mac_addr = '0;
	logic [IP_W-1:0]      ip_addr = '0;
	logic [FLAG_IN_W-1:0] block_flags = '0;
	logic                 busy;
	logic                 done;
	logic [STATUS_W-1:0]  status;
	logic [MAC_W-1:0]     found_mac;
	logic [FLAG_IN_W-1:0] found_flags;
	logic [TOTAL_W-1:0]   entry_total;

	binding_scoreboard    sb = new();
	logic [MAC_W-1:0]     mac_pool [8];
	logic [IP_W-1:0]      ip_pool [8];
	int                   cycle_count = 0;

	host_binding_table i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.mode        (mode),
		.mac_addr    (mac_addr),
		.ip_addr     (ip_addr),
		.block_flags (block_flags),
		.done        (done),
		.status      (status),
		.found_mac   (found_mac),
		.found_flags (found_flags),
		.entry_total (entry_total)
	);

	// 100 MHz clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Every strobed result word is checked against the prediction queue.
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(lookup_result_t'({status, found_mac, found_flags, entry_total}));
	end

	// Watchdog against a hung handshake.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic logic [MAC_W-1:0] rand_mac();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[MAC_W-1:0];
	endfunction

	// Mostly fresh MACs grow the table; known ones hit existing entries.
	function automatic logic [MAC_W-1:0] pick_mac(int fresh_pct);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < fresh_pct) return rand_mac();
		if (roll < fresh_pct + (100 - fresh_pct) / 2 && sb.n_entries > 0)
			return sb.mac_tab[$urandom_range(0, sb.n_entries - 1)];
		return mac_pool[$urandom_range(0, 7)];
	endfunction

	function automatic logic [IP_W-1:0] pick_ip();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 15) return $urandom;
		if (roll < 55 && sb.n_entries > 0) return sb.ip_tab[$urandom_range(0, sb.n_entries - 1)];
		return ip_pool[$urandom_range(0, 7)];
	endfunction

	function automatic logic [FLAG_IN_W-1:0] rand_flags();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll == 0) return '0;
		if (roll == 1) return '1;
		return $urandom;
	endfunction

	// Growing phases favor appends so the table fills and overflows; the others shrink it.
	function automatic logic [MODE_W-1:0] pick_mode(bit growing);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 3) return MODE_W'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
		if (growing) begin
			if (roll < 45) return MODE_LEARN;
			if (roll < 75) return MODE_REGISTER;
			if (roll < 82) return MODE_DELETE;
			if (roll < 90) return MODE_UPDATE;
			return MODE_SEARCH;
		end
		if (roll < 20) return MODE_LEARN;
		if (roll < 35) return MODE_REGISTER;
		if (roll < 60) return MODE_DELETE;
		if (roll < 78) return MODE_UPDATE;
		return MODE_SEARCH;
	endfunction

	// Presents one request word and holds it until the block takes it.
	task automatic send_word(logic [MODE_W-1:0] op, logic [MAC_W-1:0] mac,
				 logic [IP_W-1:0] ip, logic [FLAG_IN_W-1:0] flags);
		start <= 1'b1;
		mode <= op;
		mac_addr <= mac;
		ip_addr <= ip;
		block_flags <= flags;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_request(op, mac, ip, flags);
	endtask

	task automatic idle_gap(int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Holds off new words until every outstanding result has come back.
	task automatic wait_drained();
		start <= 1'b0;
		do @(posedge clk); while (sb.pending.size() != 0);
	endtask

	initial begin
		logic [MODE_W-1:0] op;
		bit growing;
		mac_pool[0] = '0;
		mac_pool[1] = '1;
		ip_pool[0] = ZERO_IP;
		ip_pool[1] = '1;
		for (int i = 2; i < 8; i++) begin
			mac_pool[i] = rand_mac();
			ip_pool[i] = $urandom;
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words: empty table, duplicates, IP change, adjacent deletes, spare modes.
		send_word(MODE_SEARCH, '0, ZERO_IP, '0);
		send_word(MODE_DELETE, '1, '0, '0);
		send_word(MODE_UPDATE, '1, '0, '1);
		send_word(MODE_LEARN, '1, '1, '1);
		send_word(MODE_LEARN, '1, '1, '0);
		send_word(MODE_LEARN, '1, ZERO_IP, '0);
		send_word(MODE_REGISTER, '1, '1, '1);
		send_word(MODE_REGISTER, '1, '0, 32'h5A5A_5A5A);
		send_word(MODE_REGISTER, '0, '1, '1);
		send_word(MODE_LEARN, '1, 32'h1234_5678, '0);
		send_word(MODE_SEARCH, '0, 32'h1234_5678, '0);
		send_word(MODE_SEARCH, '1, ZERO_IP, '1);
		send_word(MODE_UPDATE, '1, '0, 32'hA5A5_A5A5);
		send_word(MODE_UPDATE, 48'h1, '0, '1);
		send_word(MODE_DELETE, '1, '0, '0);
		send_word(MODE_SEARCH, '0, 32'h1234_5678, '0);
		send_word(MODE_DELETE, 48'h1, '0, '0);
		for (int m = MODE_SPARE_LO; m <= MODE_SPARE_HI; m++)
			send_word(MODE_W'(m), rand_mac(), $urandom, $urandom);
		send_word(MODE_LEARN, '0, '1, '0);
		send_word(MODE_SEARCH, '1, '1, '0);
		send_word(MODE_DELETE, '0, '0, '0);
		wait_drained();

		// Random words in alternating growing and shrinking phases.
		for (int k = 0; k < RANDOM_WORDS; k++) begin
			if (k > 0 && k % PHASE_WORDS == 0 && $urandom_range(0, 1) == 1) wait_drained();
			growing = ((k / PHASE_WORDS) % 2) == 0;
			op = pick_mode(growing);
			send_word(op, pick_mac(growing ? 70 : 20), pick_ip(), rand_flags());
			if (k < RANDOM_WORDS - CALM_WORDS && $urandom_range(0, 3) == 0)
				idle_gap($urandom_range(1, 5));
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.mismatch_count == 0 && sb.pending.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule
